>>> rtl/rmh_pkg.sv
// rmh_pkg: shared types for the running median block.
// Holds the sequencer state enums and the heap command struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package rmh_pkg;

  typedef enum logic {
    HOP_PUSH,
    HOP_REPLACE
  } heap_op_t;

  typedef struct packed {
    logic     start;
    heap_op_t op;
  } heap_cmd_t;

  typedef enum logic [2:0] {
    HS_IDLE,
    HS_UP_RD,
    HS_UP_CMP,
    HS_PUT,
    HS_DN_RDL,
    HS_DN_RDR,
    HS_DN_CMP
  } heap_state_t;

  typedef enum logic {
    RS_IDLE,
    RS_WAIT
  } rmh_state_t;

endpackage

`default_nettype wire

>>> rtl/rmh_heap.sv
// rmh_heap: one binary heap in a single-port memory with a sift sequencer.
// Push sifts up, replace-top sifts down, one compare unit per step.
// Depends on rmh_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rmh_heap #(
  parameter int DEPTH  = 512,
  parameter int W      = 16,
  parameter bit IS_MAX = 1'b1
) (
  input  logic                           clk,
  input  logic                           rst,
  input  rmh_pkg::heap_cmd_t             cmd,
  input  logic signed [W-1:0]            value,
  output logic                           busy,
  output logic [$clog2(DEPTH+1)-1:0]     size,
  output logic signed [W-1:0]            top
);
  import rmh_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = AW + 2;

  logic signed [W-1:0] mem [DEPTH];

  heap_state_t          state, state_next;
  logic [AW-1:0]        idx, idx_next;
  logic signed [W-1:0]  val, val_next;
  logic [$clog2(DEPTH+1)-1:0] size_next;
  logic signed [W-1:0]  cand_val, cand_val_next;
  logic [AW-1:0]        cand_idx, cand_idx_next;
  logic                 cand_hit, cand_hit_next;
  logic signed [W-1:0]  rdata;
  logic [AW-1:0]        raddr;
  logic                 we;
  logic [AW-1:0]        waddr;
  logic signed [W-1:0]  wdata;
  logic [AW-1:0]        parent;
  logic [CW-1:0]        lpos, rpos, size_ext;

  function automatic logic above(input logic signed [W-1:0] a, input logic signed [W-1:0] b);
    return IS_MAX ? (a > b) : (a < b);
  endfunction

  assign parent   = AW'((idx - AW'(1)) >> 1);
  assign lpos     = {1'b0, idx, 1'b1};
  assign rpos     = lpos + CW'(1);
  assign size_ext = CW'(size);
  assign busy     = (state != HS_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= HS_IDLE;
      size  <= '0;
    end else begin
      state <= state_next;
      size  <= size_next;
    end
    idx      <= idx_next;
    val      <= val_next;
    cand_val <= cand_val_next;
    cand_idx <= cand_idx_next;
    cand_hit <= cand_hit_next;
    if (we) begin
      mem[waddr] <= wdata;
      if (waddr == '0) begin
        top <= wdata;
      end
    end
    rdata <= mem[raddr];
  end

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    val_next      = val;
    size_next     = size;
    cand_val_next = cand_val;
    cand_idx_next = cand_idx;
    cand_hit_next = cand_hit;
    raddr         = '0;
    we            = 1'b0;
    waddr         = idx;
    wdata         = val;
    case (state)
      HS_IDLE: begin
        if (cmd.start) begin
          val_next = value;
          if (cmd.op == HOP_PUSH) begin
            size_next = size + 1'b1;
            if (size == '0) begin
              we    = 1'b1;
              waddr = '0;
              wdata = value;
            end else begin
              idx_next   = AW'(size);
              state_next = HS_UP_RD;
            end
          end else begin
            idx_next   = '0;
            state_next = HS_DN_RDL;
          end
        end
      end
      HS_UP_RD: begin
        raddr      = parent;
        state_next = HS_UP_CMP;
      end
      HS_UP_CMP: begin
        we = 1'b1;
        if (above(val, rdata)) begin
          wdata    = rdata;
          idx_next = parent;
          state_next = (parent == '0) ? HS_PUT : HS_UP_RD;
        end else begin
          state_next = HS_IDLE;
        end
      end
      HS_PUT: begin
        we         = 1'b1;
        state_next = HS_IDLE;
      end
      HS_DN_RDL: begin
        if (lpos >= size_ext) begin
          we         = 1'b1;
          state_next = HS_IDLE;
        end else begin
          raddr      = lpos[AW-1:0];
          state_next = HS_DN_RDR;
        end
      end
      HS_DN_RDR: begin
        raddr = rpos[AW-1:0];
        if (above(rdata, val)) begin
          cand_hit_next = 1'b1;
          cand_val_next = rdata;
          cand_idx_next = lpos[AW-1:0];
        end else begin
          cand_hit_next = 1'b0;
          cand_val_next = val;
          cand_idx_next = idx;
        end
        state_next = HS_DN_CMP;
      end
      HS_DN_CMP: begin
        we = 1'b1;
        if (rpos < size_ext && above(rdata, cand_val)) begin
          wdata      = rdata;
          idx_next   = rpos[AW-1:0];
          state_next = HS_DN_RDL;
        end else if (cand_hit) begin
          wdata      = cand_val;
          idx_next   = cand_idx;
          state_next = HS_DN_RDL;
        end else begin
          state_next = HS_IDLE;
        end
      end
      default: begin
        state_next = HS_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> rtl/running_median_two_heaps_core.sv
// running_median_two_heaps_core: running median over a max-heap and a min-heap.
// Routes each sample, starts heap pushes and replaces, registers the result.
// Depends on rmh_pkg and rmh_heap.
//
//   channel  | handshake            | payload
//   ---------+----------------------+-----------------------------------------
//   input    | in_valid / in_stall  | sample
//   output   | out_valid / out_stall| median_doubled, held_count, dropped
//
// A sample is taken in RS_IDLE, then RS_WAIT waits out the heap sift: a push reads
// and compares the parent of each level climbed and may place the value at the root
// in a last step; a replace-top reads the left child, reads the right child and
// compares per level descended, then places the sample; the memory read port sets these steps.
// Both heaps work in parallel when a top moves across.
// Reset clears the heap sizes and the sequencer; no clearing pass is run.
// in_stall is high while a sample is in work; a stalled result holds the block.
`timescale 1ns / 1ps
`default_nettype none

module running_median_two_heaps_core #(
  parameter int HALF_CAPACITY = 512,
  parameter int SAMPLE_WIDTH  = 16
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0]         sample,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [SAMPLE_WIDTH:0]           median_doubled,
  output logic [$clog2(2*HALF_CAPACITY+1)-1:0]   held_count,
  output logic                                   dropped
);
  import rmh_pkg::*;

  localparam int MW   = SAMPLE_WIDTH + 1;
  localparam int SZW  = $clog2(HALF_CAPACITY + 1);
  localparam int CNTW = $clog2(2 * HALF_CAPACITY + 1);

  rmh_state_t state, state_next;
  heap_cmd_t  lo_cmd, up_cmd;
  logic signed [SAMPLE_WIDTH-1:0] lo_val, up_val, lo_top, up_top;
  logic       lo_busy, up_busy;
  logic [SZW-1:0] lo_size, up_size;
  logic signed [MW-1:0] lo_ext, up_ext, m2, x2;
  logic       drop, drop_next;
  logic       load;

  rmh_heap #(.DEPTH(HALF_CAPACITY), .W(SAMPLE_WIDTH), .IS_MAX(1'b1)) u_lower (
    .clk(clk), .rst(rst), .cmd(lo_cmd), .value(lo_val),
    .busy(lo_busy), .size(lo_size), .top(lo_top)
  );

  rmh_heap #(.DEPTH(HALF_CAPACITY), .W(SAMPLE_WIDTH), .IS_MAX(1'b0)) u_upper (
    .clk(clk), .rst(rst), .cmd(up_cmd), .value(up_val),
    .busy(up_busy), .size(up_size), .top(up_top)
  );

  assign lo_ext   = {lo_top[SAMPLE_WIDTH-1], lo_top};
  assign up_ext   = {up_top[SAMPLE_WIDTH-1], up_top};
  assign x2       = {sample, 1'b0};
  assign m2       = (lo_size == up_size) ? (lo_ext + up_ext) :
                    (lo_size < up_size) ? (up_ext <<< 1) : (lo_ext <<< 1);
  assign in_stall = (state != RS_IDLE);
  assign load     = (state == RS_WAIT) && !lo_busy && !up_busy &&
                    (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= RS_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    drop <= drop_next;
    if (load) begin
      median_doubled <= m2;
      held_count     <= CNTW'(lo_size) + CNTW'(up_size);
      dropped        <= drop;
    end
  end

  always_comb begin
    state_next = state;
    drop_next  = drop;
    lo_cmd     = '{start: 1'b0, op: HOP_PUSH};
    up_cmd     = '{start: 1'b0, op: HOP_PUSH};
    lo_val     = sample;
    up_val     = sample;
    case (state)
      RS_IDLE: begin
        if (in_valid) begin
          state_next = RS_WAIT;
          drop_next  = 1'b0;
          if (lo_size == SZW'(HALF_CAPACITY) && up_size == SZW'(HALF_CAPACITY)) begin
            drop_next = 1'b1;
          end else if (lo_size == '0) begin
            lo_cmd.start = 1'b1;
          end else if (lo_size == up_size) begin
            if (x2 <= m2) begin
              lo_cmd.start = 1'b1;
            end else begin
              up_cmd.start = 1'b1;
            end
          end else if (lo_size < up_size) begin
            lo_cmd.start = 1'b1;
            if (x2 > m2) begin
              lo_val       = up_top;
              up_cmd.start = 1'b1;
              up_cmd.op    = HOP_REPLACE;
            end
          end else begin
            up_cmd.start = 1'b1;
            if (x2 < m2) begin
              up_val       = lo_top;
              lo_cmd.start = 1'b1;
              lo_cmd.op    = HOP_REPLACE;
            end
          end
        end
      end
      RS_WAIT: begin
        if (load) begin
          state_next = RS_IDLE;
        end
      end
      default: begin
        state_next = RS_IDLE;
      end
    endcase
  end

  a_balance: assert property (@(posedge clk) disable iff (rst)
    state == RS_IDLE |-> (lo_size == up_size || lo_size == up_size + 1'b1 ||
                          up_size == lo_size + 1'b1))
    else $error("heap sizes out of balance");

  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    (lo_cmd.start || up_cmd.start) |-> (!lo_busy && !up_busy))
    else $error("heap started while busy");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    (out_valid && dropped) |-> held_count == CNTW'(2 * HALF_CAPACITY))
    else $error("drop reported with free space");

  a_load_wait: assert property (@(posedge clk) disable iff (rst)
    load |=> out_valid && state == RS_IDLE)
    else $error("result not registered");

endmodule

`default_nettype wire

>>> verif/running_median_two_heaps_core_chk.sv
// Checker for running_median_two_heaps_core: watches both channels, keeps its own
// two-heap median predictor and compares every result transfer field by field.
// Depends only on the block's port widths.
`timescale 1ns / 1ps

module running_median_two_heaps_core_chk #(
  parameter int HALF_CAPACITY = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  logic               in_stall,
  input  logic signed [15:0] sample,
  input  logic               out_valid,
  input  logic               out_stall,
  input  logic signed [16:0] median_doubled,
  input  logic [10:0]        held_count,
  input  logic               dropped,
  output int                 fail_count,
  output int                 pending
);

  typedef struct packed {
    logic signed [16:0] med;
    logic [10:0]        cnt;
    logic               drop;
  } median_res_t;

  median_res_t expected_q[$];
  int lo_heap[HALF_CAPACITY];
  int hi_heap[HALF_CAPACITY];
  int lo_n, hi_n;

  function automatic bit above(int a, int b, bit is_max);
    return is_max ? (a > b) : (a < b);
  endfunction

  task automatic push(ref int h[HALF_CAPACITY], ref int n, input int v, input bit is_max);
    int i, p, t;
    i = n;
    h[i] = v;
    n = n + 1;
    while (i > 0) begin
      p = (i - 1) / 2;
      if (!above(h[i], h[p], is_max)) break;
      t = h[i]; h[i] = h[p]; h[p] = t;
      i = p;
    end
  endtask

  task automatic replace_top(ref int h[HALF_CAPACITY], input int n, input int v,
                             input bit is_max);
    int i, l, r, b, t;
    i = 0;
    h[0] = v;
    forever begin
      l = 2 * i + 1;
      r = l + 1;
      b = i;
      if (l < n && above(h[l], h[b], is_max)) b = l;
      if (r < n && above(h[r], h[b], is_max)) b = r;
      if (b == i) break;
      t = h[i]; h[i] = h[b]; h[b] = t;
      i = b;
    end
  endtask

  function automatic int median2();
    if (lo_n == hi_n) return (lo_n == 0) ? 0 : lo_heap[0] + hi_heap[0];
    if (lo_n < hi_n) return 2 * hi_heap[0];
    return 2 * lo_heap[0];
  endfunction

  task automatic predict_median(input int x);
    median_res_t r;
    int m2;
    r.drop = 0;
    if (lo_n >= HALF_CAPACITY && hi_n >= HALF_CAPACITY) begin
      r.drop = 1;
    end else if (lo_n == 0) begin
      push(lo_heap, lo_n, x, 1);
    end else begin
      m2 = median2();
      if (lo_n == hi_n) begin
        if (2 * x <= m2) push(lo_heap, lo_n, x, 1);
        else push(hi_heap, hi_n, x, 0);
      end else if (lo_n < hi_n) begin
        if (2 * x > m2) begin
          push(lo_heap, lo_n, hi_heap[0], 1);
          replace_top(hi_heap, hi_n, x, 0);
        end else begin
          push(lo_heap, lo_n, x, 1);
        end
      end else begin
        if (2 * x < m2) begin
          push(hi_heap, hi_n, lo_heap[0], 0);
          replace_top(lo_heap, lo_n, x, 1);
        end else begin
          push(hi_heap, hi_n, x, 0);
        end
      end
    end
    r.med = 17'(median2());
    r.cnt = 11'(lo_n + hi_n);
    expected_q.push_back(r);
  endtask

  always @(posedge clk) begin
    median_res_t e;
    if (rst) begin
      lo_n <= 0;
      hi_n <= 0;
      fail_count <= 0;
      pending <= 0;
      expected_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_q.size() == 0) begin
          fail_count <= fail_count + 1;
          if (fail_count < 10) $display("result transfer with nothing expected");
        end else begin
          e = expected_q.pop_front();
          if (e.med !== median_doubled || e.cnt !== held_count || e.drop !== dropped) begin
            fail_count <= fail_count + 1;
            if (fail_count < 10)
              $display("mismatch: exp med %0d cnt %0d drop %0d, got med %0d cnt %0d drop %0d",
                       e.med, e.cnt, e.drop, median_doubled, held_count, dropped);
          end
        end
      end
      if (in_valid && !in_stall) predict_median(int'(sample));
      pending <= expected_q.size();
    end
  end

endmodule

>>> verif/running_median_two_heaps_core_tb.sv
// Testbench top for running_median_two_heaps_core: drives samples in bursts,
// stalls results on its own pattern and reports the verdict.
// Depends on the block and running_median_two_heaps_core_chk.
`timescale 1ns / 1ps

module running_median_two_heaps_core_tb;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  logic signed [15:0] sample = 0;
  logic out_valid;
  logic out_stall = 0;
  logic signed [16:0] median_doubled;
  logic [10:0] held_count;
  logic dropped;
  int fail_count, pending;
  int hold_off = 0;
  int cycle = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  running_median_two_heaps_core u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall), .median_doubled(median_doubled),
    .held_count(held_count), .dropped(dropped)
  );

  running_median_two_heaps_core_chk u_chk (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall), .median_doubled(median_doubled),
    .held_count(held_count), .dropped(dropped), .fail_count(fail_count),
    .pending(pending)
  );

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle > 3000000) begin
      $display("** running_median_two_heaps_core: FAILED **");
      $finish;
    end
  end

  // receiver: long hold-off on request, otherwise a stall pattern by phase
  always @(posedge clk) begin
    if (hold_off > 0) begin
      out_stall <= 1;
      hold_off <= hold_off - 1;
    end else if (cycle % 4000 < 1500) begin
      out_stall <= 0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 40);
    end
  end

  function automatic logic [15:0] pick_sample(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 6) - 3);
      2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
      default: return 16'($urandom_range(0, 200) - 100);
    endcase
  endfunction

  task automatic send(input logic [15:0] v);
    logic taken;
    in_valid <= 1;
    sample <= v;
    taken = 0;
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
  endtask

  task automatic gap(input int n);
    in_valid <= 0;
    repeat (n) @(posedge clk);
  endtask

  initial begin
    logic [15:0] dir[] = '{16'h8000, 16'h7fff, 16'h0000, 16'hffff, 16'h0001, 16'h0000,
                           16'h0000, 16'h8000, 16'h7fff, 16'h5555, 16'haaaa, 16'h0000,
                           16'h0002, 16'hfffe, 16'h0000, 16'h7fff, 16'h8000};
    int burst;
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (dir[i]) send(dir[i]);
    gap(3);
    hold_off <= 400;
    for (int i = 0; i < 40; i++) send(pick_sample(3));
    gap(1);
    while (pending != 0) @(posedge clk);
    for (int n = 0; n < 1350;) begin
      burst = $urandom_range(1, 20);
      for (int k = 0; k < burst; k++) send(pick_sample($urandom_range(0, 3)));
      n += burst;
      if ($urandom_range(0, 2) != 0) gap($urandom_range(1, 30));
    end
    gap(1);
    while (pending != 0) @(posedge clk);
    // fill to capacity and exercise the drop path
    while (held_count < 11'd1024) begin
      send(pick_sample($urandom_range(0, 3)));
      gap(1);
      while (pending != 0) @(posedge clk);
    end
    for (int i = 0; i < 30; i++) send(pick_sample(0));
    gap(1);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0) begin
      $display("** running_median_two_heaps_core: PASSED **");
    end else begin
      $display("** running_median_two_heaps_core: FAILED **");
    end
    $finish;
  end

endmodule
